### rtl/core/chacha_pkg.sv
`default_nettype none
package chacha_pkg;

	localparam int WORD_W   = 32;
	localparam int NWORDS   = 16;
	localparam int IDX_W    = 4;
	localparam int CFG_W    = 64;
	localparam int CFG_IX_W = 3;

	localparam logic [IDX_W-1:0] WORD_LAST = IDX_W'(NWORDS - 1);

	localparam logic [CFG_IX_W-1:0] CFG_KEY01 = 3'd0;
	localparam logic [CFG_IX_W-1:0] CFG_KEY23 = 3'd1;
	localparam logic [CFG_IX_W-1:0] CFG_KEY45 = 3'd2;
	localparam logic [CFG_IX_W-1:0] CFG_KEY67 = 3'd3;
	localparam logic [CFG_IX_W-1:0] CFG_NONCE = 3'd4;

	localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
	localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
	localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
	localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} quad_t;

	// controller -> datapath
	typedef struct packed {
		logic             load;
		logic             mix;
		logic             diag;
		logic             late;
		logic             emit;
		logic [IDX_W-1:0] idx;
		logic             last;
	} cmd_t;

	function automatic word_t swap_bytes(word_t w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	// one half of a quarter round: rotations 16/12 first, 8/7 when late
	function automatic quad_t half_qr(quad_t q, logic late);
		quad_t r;
		word_t x;
		word_t y;
		r.a = q.a + q.b;
		x   = q.d ^ r.a;
		r.d = late ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
		r.c = q.c + r.d;
		y   = q.b ^ r.c;
		r.b = late ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/core/chacha20_block_keystream_top.sv
`default_nettype none
// ChaCha20 block keystream: one request (block counter) gives sixteen 32-bit words.
// Flow: the request is loaded, then mixed by four lanes doing one half quarter round per cycle,
// then the words are emitted one word per cycle through an output register; a new request
// is taken only once the controller has returned to idle after issuing the last word.
// The receiver cannot stall: result_valid marks each word for exactly one cycle.
// Async reset clears control, the output strobe and all key/nonce registers to zero.
module chacha20_block_keystream_top #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [chacha_pkg::WORD_W-1:0]    block_counter,
	input  wire logic                             cfg_wr_en,
	input  wire logic [chacha_pkg::CFG_IX_W-1:0]  cfg_index,
	input  wire logic [chacha_pkg::CFG_W-1:0]     cfg_data,
	output logic                                  result_valid,
	output logic [chacha_pkg::WORD_W-1:0]         keystream_word,
	output logic [chacha_pkg::IDX_W-1:0]          word_index,
	output logic                                  last_word
);
	import chacha_pkg::*;

	cmd_t cmd;

	chacha_ctrl #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	chacha_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.block_counter  (block_counter),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.keystream_word (keystream_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

endmodule
`default_nettype wire

### rtl/core/chacha_ctrl.sv
`default_nettype none
module chacha_ctrl #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	output chacha_pkg::cmd_t      cmd
);
	import chacha_pkg::*;

	localparam int STEPS = 4 * DOUBLE_ROUNDS;
	localparam int SW    = $clog2(STEPS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MIX  = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [SW-1:0]    step_q;
	logic [IDX_W-1:0] idx_q;

	assign busy     = (state_q != S_IDLE);
	assign cmd.load = start && (state_q == S_IDLE);
	assign cmd.mix  = (state_q == S_MIX);
	assign cmd.late = step_q[0];
	assign cmd.diag = step_q[1];
	assign cmd.emit = (state_q == S_EMIT);
	assign cmd.idx  = idx_q;
	assign cmd.last = (idx_q == WORD_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MIX;
						step_q  <= '0;
					end
				end
				S_MIX: begin
					if (step_q == SW'(STEPS - 1)) begin
						state_q <= S_EMIT;
						idx_q   <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (idx_q == WORD_LAST) begin
						state_q <= S_IDLE;
					end
					idx_q <= idx_q + 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/chacha_dp.sv
`default_nettype none
module chacha_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire chacha_pkg::cmd_t                       cmd,
	input  wire logic [chacha_pkg::WORD_W-1:0]          block_counter,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [chacha_pkg::CFG_IX_W-1:0]        cfg_index,
	input  wire logic [chacha_pkg::CFG_W-1:0]           cfg_data,
	output logic                                        result_valid,
	output logic [chacha_pkg::WORD_W-1:0]               keystream_word,
	output logic [chacha_pkg::IDX_W-1:0]                word_index,
	output logic                                        last_word
);
	import chacha_pkg::*;

	logic [CFG_W-1:0] key01_q, key23_q, key45_q, key67_q, nonce_q;
	word_t            cnt_q;
	word_t            st_q [NWORDS];
	word_t            st_d [NWORDS];
	word_t            init_w [NWORDS];
	word_t            cnt_sel;
	quad_t            qin [4];
	quad_t            qout [4];

	logic             valid_q;
	word_t            word_q;
	logic [IDX_W-1:0] index_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q <= '0;
			key23_q <= '0;
			key45_q <= '0;
			key67_q <= '0;
			nonce_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_KEY01: key01_q <= cfg_data;
				CFG_KEY23: key23_q <= cfg_data;
				CFG_KEY45: key45_q <= cfg_data;
				CFG_KEY67: key67_q <= cfg_data;
				CFG_NONCE: nonce_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// initial state; counter comes straight from the port on the load cycle
	assign cnt_sel = cmd.load ? block_counter : cnt_q;

	always_comb begin
		init_w[0]  = SIGMA0;
		init_w[1]  = SIGMA1;
		init_w[2]  = SIGMA2;
		init_w[3]  = SIGMA3;
		init_w[4]  = swap_bytes(key01_q[31:0]);
		init_w[5]  = swap_bytes(key01_q[63:32]);
		init_w[6]  = swap_bytes(key23_q[31:0]);
		init_w[7]  = swap_bytes(key23_q[63:32]);
		init_w[8]  = swap_bytes(key45_q[31:0]);
		init_w[9]  = swap_bytes(key45_q[63:32]);
		init_w[10] = swap_bytes(key67_q[31:0]);
		init_w[11] = swap_bytes(key67_q[63:32]);
		init_w[12] = cnt_sel;
		init_w[13] = '0;
		init_w[14] = nonce_q[31:0];
		init_w[15] = nonce_q[63:32];
	end

	// four quarter-round lanes; diagonal rounds rotate the b/c/d rows
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			qin[j].a = st_q[j];
			qin[j].b = cmd.diag ? st_q[4 + ((j + 1) % 4)]  : st_q[4 + j];
			qin[j].c = cmd.diag ? st_q[8 + ((j + 2) % 4)]  : st_q[8 + j];
			qin[j].d = cmd.diag ? st_q[12 + ((j + 3) % 4)] : st_q[12 + j];
			qout[j]  = half_qr(qin[j], cmd.late);
		end
	end

	always_comb begin
		for (int k = 0; k < NWORDS; k++) begin
			st_d[k] = st_q[k];
		end
		if (cmd.load) begin
			for (int k = 0; k < NWORDS; k++) begin
				st_d[k] = init_w[k];
			end
		end else if (cmd.mix) begin
			for (int j = 0; j < 4; j++) begin
				st_d[j] = qout[j].a;
				if (cmd.diag) begin
					st_d[4 + ((j + 1) % 4)]  = qout[j].b;
					st_d[8 + ((j + 2) % 4)]  = qout[j].c;
					st_d[12 + ((j + 3) % 4)] = qout[j].d;
				end else begin
					st_d[4 + j]  = qout[j].b;
					st_d[8 + j]  = qout[j].c;
					st_d[12 + j] = qout[j].d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NWORDS; k++) begin
			st_q[k] <= st_d[k];
		end
		if (cmd.load) begin
			cnt_q <= block_counter;
		end
		word_q  <= st_q[cmd.idx] + init_w[cmd.idx];
		index_q <= cmd.idx;
		last_q  <= cmd.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
		end
	end

	assign result_valid   = valid_q;
	assign keystream_word = word_q;
	assign word_index     = index_q;
	assign last_word      = last_q;

endmodule
`default_nettype wire

### verif/chacha20_block_keystream_checker.sv
`timescale 1ns / 100ps
module chacha20_block_keystream_checker
	import chacha_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire logic [WORD_W-1:0]   block_counter,
	input  wire logic                cfg_wr_en,
	input  wire logic [CFG_IX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_data,
	input  wire logic                result_valid,
	input  wire logic [WORD_W-1:0]   keystream_word,
	input  wire logic [IDX_W-1:0]    word_index,
	input  wire logic                last_word,
	output int                       fail_count,
	output int                       pending
);

	typedef logic [NWORDS-1:0][WORD_W-1:0] block_t;

	typedef struct packed {
		word_t            data;
		logic [IDX_W-1:0] idx;
		logic             last;
	} ks_word_t;

	ks_word_t         keystream_q[$];
	logic [CFG_W-1:0] key_reg[4];
	logic [CFG_W-1:0] nonce_reg;
	int               errors;

	function automatic word_t rotl(input word_t w, input int n);
		return (w << n) | (w >> (WORD_W - n));
	endfunction

	function automatic word_t bswap(input word_t w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	function automatic block_t qround(input block_t s, input int a, input int b, input int c,
			input int d);
		s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 16);
		s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 12);
		s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 8);
		s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 7);
		return s;
	endfunction

	// full keystream block for one counter under the current key/nonce
	function automatic block_t chacha_block(input word_t ctr);
		block_t init;
		block_t x;
		init[0] = SIGMA0;
		init[1] = SIGMA1;
		init[2] = SIGMA2;
		init[3] = SIGMA3;
		for (int k = 0; k < 4; k++) begin
			init[4 + 2 * k] = bswap(key_reg[k][31:0]);
			init[5 + 2 * k] = bswap(key_reg[k][63:32]);
		end
		init[12] = ctr;
		init[13] = '0;
		init[14] = nonce_reg[31:0];
		init[15] = nonce_reg[63:32];
		x = init;
		for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
			x = qround(x, 0, 4, 8, 12);
			x = qround(x, 1, 5, 9, 13);
			x = qround(x, 2, 6, 10, 14);
			x = qround(x, 3, 7, 11, 15);
			x = qround(x, 0, 5, 10, 15);
			x = qround(x, 1, 6, 11, 12);
			x = qround(x, 2, 7, 8, 13);
			x = qround(x, 3, 4, 9, 14);
		end
		for (int k = 0; k < NWORDS; k++)
			x[k] = x[k] + init[k];
		return x;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ks_word_t exp_w;
		block_t   blk;
		if (!arst_n) begin
			for (int k = 0; k < 4; k++)
				key_reg[k] = '0;
			nonce_reg = '0;
			keystream_q.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_KEY01: key_reg[0] = cfg_data;
					CFG_KEY23: key_reg[1] = cfg_data;
					CFG_KEY45: key_reg[2] = cfg_data;
					CFG_KEY67: key_reg[3] = cfg_data;
					CFG_NONCE: nonce_reg = cfg_data;
					default: ; // unmapped index: write dropped
				endcase
			end

			if (result_valid) begin
				if (keystream_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected keystream word: idx %0d data %08h last %0b",
							word_index, keystream_word, last_word);
				end else begin
					exp_w = keystream_q.pop_front();
					if (exp_w.data !== keystream_word || exp_w.idx !== word_index ||
							exp_w.last !== last_word) begin
						errors++;
						if (errors <= 10)
							$display("keystream mismatch: exp %08h idx %0d last %0b, got %08h idx %0d last %0b",
								exp_w.data, exp_w.idx, exp_w.last,
								keystream_word, word_index, last_word);
					end
				end
			end

			if (start && !busy) begin
				blk = chacha_block(block_counter);
				for (int k = 0; k < NWORDS; k++)
					keystream_q.push_back('{data: blk[k], idx: IDX_W'(k),
						last: (IDX_W'(k) == WORD_LAST)});
			end

			fail_count <= errors;
			pending <= keystream_q.size();
		end
	end

endmodule

### verif/tb_chacha20_block_keystream_top.sv
`timescale 1ns / 100ps
module tb_chacha20_block_keystream_top;
	import chacha_pkg::*;

	localparam int DOUBLE_ROUNDS = 10;
	localparam int BLOCK_CYCLES  = 4 * DOUBLE_ROUNDS + 17;
	localparam int RUN_LIMIT     = 300000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 40;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [WORD_W-1:0]   block_counter = '0;
	logic                cfg_wr_en = 1'b0;
	logic [CFG_IX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                result_valid;
	logic [WORD_W-1:0]   keystream_word;
	logic [IDX_W-1:0]    word_index;
	logic                last_word;
	int                  fail_count;
	int                  pending;
	int                  cycle_count = 0;
	bit                  idle_on = 1'b1;

	always #6 clk = ~clk;

	chacha20_block_keystream_top #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.block_counter(block_counter),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.keystream_word(keystream_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	chacha20_block_keystream_checker #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.block_counter(block_counter),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.keystream_word(keystream_word),
		.word_index(word_index),
		.last_word(last_word),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [CFG_W-1:0] pick64();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// caller lowers cfg_wr_en after the last write
	task automatic write_reg(input logic [CFG_IX_W-1:0] ix, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= ix;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_all(input logic [CFG_W-1:0] k01, input logic [CFG_W-1:0] k23,
			input logic [CFG_W-1:0] k45, input logic [CFG_W-1:0] k67,
			input logic [CFG_W-1:0] nonce);
		write_reg(CFG_KEY01, k01);
		write_reg(CFG_KEY23, k23);
		write_reg(CFG_KEY45, k45);
		write_reg(CFG_KEY67, k67);
		write_reg(CFG_NONCE, nonce);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic write_unmapped();
		for (int ix = CFG_NONCE + 1; ix < (1 << CFG_IX_W); ix++)
			write_reg(CFG_IX_W'(ix), {$urandom, $urandom});
		cfg_wr_en <= 1'b0;
	endtask

	// hold start high until the request is taken; gap 0 leaves it high for the next one
	task automatic send_block(input logic [WORD_W-1:0] ctr);
		int gap;
		bit late;
		start <= 1'b1;
		block_counter <= ctr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		gap = idle_on ? $urandom_range(0, 3) : 0;
		late = 1'($urandom_range(0, 1));
		if (gap != 0) begin
			start <= 1'b0;
			block_counter <= $urandom;
			@(posedge clk);
			if (late)
				while (busy)
					@(posedge clk);
			repeat (gap - 1)
				@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
	endtask

	initial begin
		logic [WORD_W-1:0] seq_ctr;
		logic [WORD_W-1:0] ctr;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		// reset key and nonce, counter extremes
		send_block('0);
		send_block('1);
		send_block(32'h0000_0001);
		send_block(32'h8000_0000);
		drain();

		load_all('1, '1, '1, '1, '1);
		send_block('0);
		send_block('1);
		send_block(32'h7fff_ffff);
		drain();

		load_all(64'h0f0e0d0c_0b0a0908, 64'h07060504_03020100, 64'h1f1e1d1c_1b1a1918,
			64'h17161514_13121110, 64'h4a000000_09000000);
		write_unmapped(); // must leave key and nonce alone
		send_block(32'h0000_0001);
		send_block(32'h5555_5555);
		send_block(32'haaaa_aaaa);
		send_block('1);
		send_block('0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			for (int ix = CFG_KEY01; ix <= CFG_NONCE; ix++)
				if (ph == 0 || $urandom_range(0, 3) != 0)
					write_reg(CFG_IX_W'(ix), pick64());
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_IX_W'($urandom_range(CFG_NONCE + 1, (1 << CFG_IX_W) - 1)),
					{$urandom, $urandom});
			cfg_wr_en <= 1'b0;
			idle_on = ($urandom_range(0, 3) != 0);
			seq_ctr = $urandom;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 7))
					0: ctr = $urandom_range(0, 1) ? '0 : '1;
					1, 2: begin
						ctr = seq_ctr;
						seq_ctr = seq_ctr + 1;
					end
					default: ctr = $urandom;
				endcase
				send_block(ctr);
			end
		end

		drain();
		repeat (BLOCK_CYCLES + 8)
			@(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
